// File: design/clwq_pkg.sv
// ----------------------------------------------------------------------------
// Concurrency limiter package
// Shared constants, result action codes and the controller command type.
// ----------------------------------------------------------------------------
package clwq_pkg;

    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_TAG_WIDTH   = 8;
    localparam int ACTIVE_WIDTH    = 16;
    localparam int LIMIT_WIDTH     = 17;
    localparam int ACTION_WIDTH    = 2;

    localparam logic [ACTION_WIDTH-1:0] ACT_GRANT   = 2'd0;
    localparam logic [ACTION_WIDTH-1:0] ACT_CANCEL  = 2'd1;
    localparam logic [ACTION_WIDTH-1:0] ACT_QUEUED  = 2'd2;
    localparam logic [ACTION_WIDTH-1:0] ACT_NOTHING = 2'd3;

    typedef struct packed {
        logic capture;
        logic commit;
    } clwq_cmd_t;

endpackage

// File: design/clwq_if.sv
// ----------------------------------------------------------------------------
// Concurrency limiter channel interfaces
// Request channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface clwq_req_if #(
    parameter int TAG_WIDTH = clwq_pkg::DEF_TAG_WIDTH
);
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [TAG_WIDTH-1:0] request_tag;

    modport source (output valid, output mode, output request_tag, input ready);
    modport sink   (input valid, input mode, input request_tag, output ready);
endinterface

interface clwq_rsp_if #(
    parameter int TAG_WIDTH   = clwq_pkg::DEF_TAG_WIDTH,
    parameter int COUNT_WIDTH = $clog2(clwq_pkg::DEF_QUEUE_DEPTH + 1)
);
    logic                                 valid;
    logic                                 ready;
    logic [clwq_pkg::ACTION_WIDTH-1:0]    action;
    logic [TAG_WIDTH-1:0]                 result_tag;
    logic                                 overflow;
    logic [clwq_pkg::ACTIVE_WIDTH-1:0]    active_now;
    logic [COUNT_WIDTH-1:0]               waiting_now;

    modport source (output valid, output action, output result_tag, output overflow,
                    output active_now, output waiting_now, input ready);
    modport sink   (input valid, input action, input result_tag, input overflow,
                    input active_now, input waiting_now, output ready);
endinterface

// File: design/concurrency_limiter_with_wait_queue_unit.sv
// ----------------------------------------------------------------------------
// Concurrency limiter with wait queue
// Counting semaphore that grants, queues or cancels tagged requests.
// ----------------------------------------------------------------------------
// Each item is accepted in the idle state, while the head of the wait queue
// memory is read into its output register; the decision, counter update and
// queue push or pop happen afterwards, in the execute state. The
// result sits in an output register, so the next item is accepted as soon as
// the decision is made, even while the previous result is still waiting to be
// taken; the decision for that next item then waits until the previous result
// has been taken. The limit register may be written at any time the block is
// idle.
module concurrency_limiter_with_wait_queue_unit #(
    parameter int QUEUE_DEPTH = clwq_pkg::DEF_QUEUE_DEPTH,
    parameter int TAG_WIDTH   = clwq_pkg::DEF_TAG_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [clwq_pkg::LIMIT_WIDTH-1:0] cfg_wr_data,
    clwq_req_if.sink                         req,
    clwq_rsp_if.source                       rsp
);

    localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

    clwq_pkg::clwq_cmd_t cmd;
    logic                in_ready;
    logic                out_valid;

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

    clwq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    clwq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_WIDTH   (TAG_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_mode     (req.mode),
        .in_tag      (req.request_tag),
        .action      (rsp.action),
        .result_tag  (rsp.result_tag),
        .overflow    (rsp.overflow),
        .active_now  (rsp.active_now),
        .waiting_now (rsp.waiting_now)
    );

endmodule

// File: design/clwq_ctrl.sv
// ----------------------------------------------------------------------------
// Concurrency limiter controller
// Two-state sequencer for the input handshake and the result register valid.
// ----------------------------------------------------------------------------
module clwq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output clwq_pkg::clwq_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_free    = !out_valid_reg || out_ready;
    assign cmd.capture = in_valid && in_ready;
    assign cmd.commit  = (state_reg == S_EXEC) && out_free;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: design/clwq_dp.sv
// ----------------------------------------------------------------------------
// Concurrency limiter datapath
// Limit register, active counter, wait queue memory and result registers.
// ----------------------------------------------------------------------------
module clwq_dp #(
    parameter int QUEUE_DEPTH = clwq_pkg::DEF_QUEUE_DEPTH,
    parameter int TAG_WIDTH   = clwq_pkg::DEF_TAG_WIDTH,
    parameter int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  clwq_pkg::clwq_cmd_t                  cmd,
    input  logic                                 cfg_wr_en,
    input  logic [clwq_pkg::LIMIT_WIDTH-1:0]     cfg_wr_data,
    input  logic                                 in_mode,
    input  logic [TAG_WIDTH-1:0]                 in_tag,
    output logic [clwq_pkg::ACTION_WIDTH-1:0]    action,
    output logic [TAG_WIDTH-1:0]                 result_tag,
    output logic                                 overflow,
    output logic [clwq_pkg::ACTIVE_WIDTH-1:0]    active_now,
    output logic [COUNT_WIDTH-1:0]               waiting_now
);

    localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
    localparam int AW        = clwq_pkg::ACTIVE_WIDTH;

    logic [TAG_WIDTH-1:0] wait_mem [QUEUE_DEPTH];

    logic [clwq_pkg::LIMIT_WIDTH-1:0]  max_active_reg;
    logic [AW-1:0]                     active_reg;
    logic [AW-1:0]                     active_next;
    logic [PTR_WIDTH-1:0]              head_reg;
    logic [PTR_WIDTH-1:0]              head_next;
    logic [PTR_WIDTH-1:0]              tail_reg;
    logic [PTR_WIDTH-1:0]              tail_next;
    logic [COUNT_WIDTH-1:0]            count_reg;
    logic [COUNT_WIDTH-1:0]            count_next;
    logic                              mode_reg;
    logic [TAG_WIDTH-1:0]              tag_reg;
    logic [TAG_WIDTH-1:0]              head_data_reg;

    logic [clwq_pkg::ACTION_WIDTH-1:0] action_reg;
    logic [clwq_pkg::ACTION_WIDTH-1:0] action_next;
    logic [TAG_WIDTH-1:0]              rtag_reg;
    logic [TAG_WIDTH-1:0]              rtag_next;
    logic                              ovf_reg;
    logic                              ovf_next;
    logic [AW-1:0]                     active_now_reg;
    logic [COUNT_WIDTH-1:0]            waiting_now_reg;

    logic          push;
    logic          unlimited;
    logic          limit_zero;
    logic          slot_free;
    logic          queue_full;
    logic [AW-1:0] active_dec;

    assign unlimited  = max_active_reg[clwq_pkg::LIMIT_WIDTH-1];
    assign limit_zero = (max_active_reg == '0);
    assign slot_free  = (active_reg < max_active_reg[AW-1:0]);
    assign queue_full = (count_reg == COUNT_WIDTH'(QUEUE_DEPTH));
    assign active_dec = (active_reg != '0) ? (active_reg - AW'(1)) : active_reg;

    always_comb
    begin
        active_next = active_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        push        = 1'b0;
        action_next = clwq_pkg::ACT_NOTHING;
        rtag_next   = '0;
        ovf_next    = 1'b0;
        if (!mode_reg)
        begin
            rtag_next = tag_reg;
            if (limit_zero)
            begin
                action_next = clwq_pkg::ACT_CANCEL;
            end
            else if (unlimited || slot_free)
            begin
                action_next = clwq_pkg::ACT_GRANT;
                if (active_reg != '1)
                begin
                    active_next = active_reg + AW'(1);
                end
            end
            else if (queue_full)
            begin
                action_next = clwq_pkg::ACT_CANCEL;
                ovf_next    = 1'b1;
            end
            else
            begin
                action_next = clwq_pkg::ACT_QUEUED;
                push        = 1'b1;
                count_next  = count_reg + COUNT_WIDTH'(1);
                tail_next   = (tail_reg == PTR_WIDTH'(QUEUE_DEPTH - 1)) ?
                              '0 : tail_reg + PTR_WIDTH'(1);
            end
        end
        else
        begin
            active_next = active_dec;
            if (count_reg != '0)
            begin
                action_next = clwq_pkg::ACT_GRANT;
                rtag_next   = head_data_reg;
                count_next  = count_reg - COUNT_WIDTH'(1);
                head_next   = (head_reg == PTR_WIDTH'(QUEUE_DEPTH - 1)) ?
                              '0 : head_reg + PTR_WIDTH'(1);
                active_next = active_dec + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        head_data_reg <= wait_mem[head_reg];
        if (cmd.commit && push)
        begin
            wait_mem[tail_reg] <= tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= in_mode;
            tag_reg  <= in_tag;
        end
        if (cmd.commit)
        begin
            action_reg      <= action_next;
            rtag_reg        <= rtag_next;
            ovf_reg         <= ovf_next;
            active_now_reg  <= active_next;
            waiting_now_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_active_reg <= '1;
            active_reg     <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_active_reg <= cfg_wr_data;
            end
            if (cmd.commit)
            begin
                active_reg <= active_next;
                head_reg   <= head_next;
                tail_reg   <= tail_next;
                count_reg  <= count_next;
            end
        end
    end

    assign action      = action_reg;
    assign result_tag  = rtag_reg;
    assign overflow    = ovf_reg;
    assign active_now  = active_now_reg;
    assign waiting_now = waiting_now_reg;

endmodule
